@@ rtl/hfr_pkg.sv @@
// Shared types and constants for the hydrostatic face reconstruction pipeline.
package hfr_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned DEPTH_W    = 31;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned QUOT_W     = WORD_W + FRAC_W;       // |q| << 16
    localparam int unsigned DIV_STEPS  = 4;                     // quotient bits per stage
    localparam int unsigned DIV_STAGES = QUOT_W / DIV_STEPS;
    localparam int unsigned MUL_SPLIT  = QUOT_W / 2;            // partial product split
    localparam int unsigned PP_W       = DEPTH_W + MUL_SPLIT;
    localparam int unsigned PROD_W     = DEPTH_W + QUOT_W;
    localparam int unsigned NUM_STG    = 1 + DIV_STAGES + 2;    // front, divide, multiply x2
    localparam int unsigned NUM_LANES  = 4;

    localparam logic [DEPTH_W-1:0] THRESH_RESET = DEPTH_W'(66);

    // discharge lanes
    localparam int unsigned LANE_HU_NEG = 0;
    localparam int unsigned LANE_HV_NEG = 1;
    localparam int unsigned LANE_HU_POS = 2;
    localparam int unsigned LANE_HV_POS = 3;

    typedef struct packed {
        logic signed [WORD_W-1:0]     fb;
        logic [1:0][DEPTH_W-1:0]      hst;
        logic [1:0][WORD_W-1:0]       dag;
        logic [NUM_LANES-1:0]         neg;
        logic [1:0]                   zero;
    } t_face;

endpackage

@@ rtl/hfr_front.sv @@
// Front stage: face bed, reconstructed depths, Z dagger and divider operands.
module hfr_front
    import hfr_pkg::*;
(
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [DEPTH_W-1:0]                 i_thr,
    input  logic [1:0][WORD_W-1:0]             i_bed,
    input  logic [1:0][DEPTH_W-1:0]            i_depth,
    input  logic [1:0][WORD_W-1:0]             i_hu,
    input  logic [1:0][WORD_W-1:0]             i_hv,
    input  logic [1:0]                         i_act,
    output t_face                              o_face,
    output logic [NUM_LANES-1:0][QUOT_W-1:0]   o_dvd,
    output logic [1:0][DEPTH_W-1:0]            o_dvs
);

    t_face                              n_face;
    t_face                              r_face;
    logic [NUM_LANES-1:0][QUOT_W-1:0]   n_dvd;
    logic [NUM_LANES-1:0][QUOT_W-1:0]   r_dvd;
    logic [1:0][DEPTH_W-1:0]            r_dvs;
    logic signed [WORD_W-1:0]           fb;
    logic signed [WORD_W:0]             eta [2];
    logic signed [WORD_W+1:0]           h   [2];
    logic [NUM_LANES-1:0][WORD_W-1:0]   q;

    always_comb begin
        if (i_act[0] && i_act[1]) begin
            fb = ($signed(i_bed[0]) > $signed(i_bed[1])) ? i_bed[0] : i_bed[1];
        end else if (i_act[0]) begin
            fb = i_bed[0];
        end else if (i_act[1]) begin
            fb = i_bed[1];
        end else begin
            fb = '0;
        end
        q = {i_hv[1], i_hu[1], i_hv[0], i_hu[0]};
        n_face    = '0;
        n_face.fb = fb;
        for (int s = 0; s < 2; s++) begin
            eta[s] = $signed({i_bed[s][WORD_W-1], i_bed[s]}) + $signed({2'b00, i_depth[s]});
            h[s]   = $signed({eta[s][WORD_W], eta[s]}) - $signed({{2{fb[WORD_W-1]}}, fb});
            if (!i_act[s] || h[s][WORD_W+1]) begin
                n_face.hst[s] = '0;
            end else if (|h[s][WORD_W:DEPTH_W]) begin
                n_face.hst[s] = '1;
            end else begin
                n_face.hst[s] = h[s][DEPTH_W-1:0];
            end
            n_face.dag[s]  = ($signed({eta[s][WORD_W], eta[s]}) < $signed({{2{fb[WORD_W-1]}}, fb}))
                             ? eta[s][WORD_W-1:0] : fb;
            n_face.zero[s] = (i_depth[s] <= i_thr) || (i_depth[s] == '0);
        end
        for (int l = 0; l < NUM_LANES; l++) begin
            n_face.neg[l] = q[l][WORD_W-1];
            n_dvd[l] = {(q[l][WORD_W-1] ? (~q[l] + WORD_W'(1)) : q[l]), {FRAC_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_face <= n_face;
            r_dvd  <= n_dvd;
            r_dvs  <= i_depth;
        end
    end

    assign o_face = r_face;
    assign o_dvd  = r_dvd;
    assign o_dvs  = r_dvs;

endmodule

@@ rtl/hfr_div.sv @@
// Pipelined restoring divider, a few quotient bits per stage.
module hfr_div
    import hfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [QUOT_W-1:0]    i_dvd,
    input  logic [DEPTH_W-1:0]   i_dvs,
    output logic [QUOT_W-1:0]    o_quot
);

    // dividend shifts out at the top while quotient bits shift in at the bottom
    logic [QUOT_W-1:0]  r_dq  [DIV_STAGES];
    logic [DEPTH_W-1:0] r_rem [DIV_STAGES];
    logic [DEPTH_W-1:0] r_dvs [DIV_STAGES];
    logic [QUOT_W-1:0]  n_dq  [DIV_STAGES];
    logic [DEPTH_W-1:0] n_rem [DIV_STAGES];

    always_comb begin
        logic [QUOT_W-1:0]  dq;
        logic [DEPTH_W-1:0] rem;
        logic [DEPTH_W-1:0] dvs;
        logic [DEPTH_W:0]   t;
        for (int k = 0; k < DIV_STAGES; k++) begin
            dq  = (k == 0) ? i_dvd : r_dq[(k == 0) ? 0 : k-1];
            rem = (k == 0) ? '0    : r_rem[(k == 0) ? 0 : k-1];
            dvs = (k == 0) ? i_dvs : r_dvs[(k == 0) ? 0 : k-1];
            for (int j = 0; j < DIV_STEPS; j++) begin
                t = {rem, dq[QUOT_W-1]};
                if (t >= {1'b0, dvs}) begin
                    t  = t - {1'b0, dvs};
                    dq = {dq[QUOT_W-2:0], 1'b1};
                end else begin
                    dq = {dq[QUOT_W-2:0], 1'b0};
                end
                rem = t[DEPTH_W-1:0];
            end
            n_dq[k]  = dq;
            n_rem[k] = rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dq[k]  <= n_dq[k];
                r_rem[k] <= n_rem[k];
                r_dvs[k] <= (k == 0) ? i_dvs : r_dvs[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign o_quot = r_dq[DIV_STAGES-1];

endmodule

@@ rtl/hfr_scale.sv @@
// Depth times velocity: split multiply, then sum, shift, saturate and apply the sign.
module hfr_scale
    import hfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [DEPTH_W-1:0]   i_hst,
    input  logic [QUOT_W-1:0]    i_mag,
    input  logic                 i_neg,
    output logic [WORD_W-1:0]    o_res
);

    logic [PP_W-1:0]    r_pl;
    logic [PP_W-1:0]    r_ph;
    logic               r_neg;
    logic [WORD_W-1:0]  r_res;
    logic [PROD_W-1:0]  sum;
    logic               sat;
    logic [DEPTH_W-1:0] prod;
    logic [WORD_W-1:0]  n_res;

    always_comb begin
        sum  = {r_ph, {MUL_SPLIT{1'b0}}} + PROD_W'(r_pl);
        sat  = |sum[PROD_W-1:DEPTH_W+FRAC_W];
        prod = sum[DEPTH_W+FRAC_W-1:FRAC_W];
        if (r_neg) begin
            n_res = sat ? {1'b1, {(WORD_W-1){1'b0}}} : (~{1'b0, prod} + WORD_W'(1));
        end else begin
            n_res = sat ? {1'b0, {(WORD_W-1){1'b1}}} : {1'b0, prod};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl  <= PP_W'(i_hst) * PP_W'(i_mag[MUL_SPLIT-1:0]);
            r_ph  <= PP_W'(i_hst) * PP_W'(i_mag[QUOT_W-1:MUL_SPLIT]);
            r_neg <= i_neg;
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

@@ rtl/hydrostatic_face_reconstruction_top.sv @@
// Top level of the hydrostatic face reconstruction pipeline.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready  | bed, depth, hu, hv, active per side
//  out     | output    | o_out_valid / i_out_ready| face bed, depths, discharges, Z dagger
//  cfg     | input     | i_cfg_valid / o_cfg_ready| depth_threshold (31 bits)
//
// One face per cycle sustained while the output is taken; the path from input to output
// transaction is one front stage, 12 divider stages (4 quotient bits each), and
// two multiply stages (partial products, then sum and saturate).
// The whole pipeline advances together; it freezes only when the last stage
// holds a result that is not taken, so a stall loses and repeats nothing.
// Synchronous active-low reset clears the valid bits and sets the threshold to 66.
module hydrostatic_face_reconstruction_top
    import hfr_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [WORD_W-1:0]   i_bed_neg,
    input  logic [DEPTH_W-1:0]         i_depth_neg,
    input  logic signed [WORD_W-1:0]   i_hu_neg,
    input  logic signed [WORD_W-1:0]   i_hv_neg,
    input  logic                       i_active_neg,
    input  logic signed [WORD_W-1:0]   i_bed_pos,
    input  logic [DEPTH_W-1:0]         i_depth_pos,
    input  logic signed [WORD_W-1:0]   i_hu_pos,
    input  logic signed [WORD_W-1:0]   i_hv_pos,
    input  logic                       i_active_pos,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [WORD_W-1:0]   o_face_bed,
    output logic [DEPTH_W-1:0]         o_depth_star_neg,
    output logic [DEPTH_W-1:0]         o_depth_star_pos,
    output logic signed [WORD_W-1:0]   o_hu_star_neg,
    output logic signed [WORD_W-1:0]   o_hv_star_neg,
    output logic signed [WORD_W-1:0]   o_hu_star_pos,
    output logic signed [WORD_W-1:0]   o_hv_star_pos,
    output logic signed [WORD_W-1:0]   o_bed_dagger_neg,
    output logic signed [WORD_W-1:0]   o_bed_dagger_pos,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [DEPTH_W-1:0]         i_cfg_data
);

    logic [NUM_STG-1:0]                 r_vld;
    logic [DEPTH_W-1:0]                 r_thr;
    t_face                              r_bund [1:NUM_STG-1];
    t_face                              front_face;
    logic [NUM_LANES-1:0][QUOT_W-1:0]   dvd;
    logic [1:0][DEPTH_W-1:0]            dvs;
    logic [NUM_LANES-1:0][QUOT_W-1:0]   quot;
    logic [NUM_LANES-1:0][WORD_W-1:0]   res;
    logic                               adv;
    t_face                              last;

    // whole pipeline moves when the output slot is empty or being taken
    assign adv         = !r_vld[NUM_STG-1] || i_out_ready;
    assign o_in_ready  = adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NUM_STG-2:0], i_in_valid};
        end
    end

    hfr_front u_front (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_thr   (r_thr),
        .i_bed   ({i_bed_pos, i_bed_neg}),
        .i_depth ({i_depth_pos, i_depth_neg}),
        .i_hu    ({i_hu_pos, i_hu_neg}),
        .i_hv    ({i_hv_pos, i_hv_neg}),
        .i_act   ({i_active_pos, i_active_neg}),
        .o_face  (front_face),
        .o_dvd   (dvd),
        .o_dvs   (dvs)
    );

    // side data rides alongside the divider and multiplier stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_bund[1] <= front_face;
            for (int k = 2; k < NUM_STG; k++) begin
                r_bund[k] <= r_bund[k-1];
            end
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        logic [QUOT_W-1:0] mag;

        hfr_div u_div (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_dvd  (dvd[l]),
            .i_dvs  (dvs[l/2]),
            .o_quot (quot[l])
        );

        // shallow or empty cell: velocity is zero
        assign mag = r_bund[DIV_STAGES].zero[l/2] ? '0 : quot[l];

        hfr_scale u_scale (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_hst (r_bund[DIV_STAGES].hst[l/2]),
            .i_mag (mag),
            .i_neg (r_bund[DIV_STAGES].neg[l]),
            .o_res (res[l])
        );
    end

    assign last             = r_bund[NUM_STG-1];
    assign o_out_valid      = r_vld[NUM_STG-1];
    assign o_face_bed       = last.fb;
    assign o_depth_star_neg = last.hst[0];
    assign o_depth_star_pos = last.hst[1];
    assign o_bed_dagger_neg = last.dag[0];
    assign o_bed_dagger_pos = last.dag[1];
    assign o_hu_star_neg    = res[LANE_HU_NEG];
    assign o_hv_star_neg    = res[LANE_HV_NEG];
    assign o_hu_star_pos    = res[LANE_HU_POS];
    assign o_hv_star_pos    = res[LANE_HV_POS];

    // an accepted transaction always enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_vld[0])
        else $error("accepted transaction not in front stage");

    // zero reconstructed depth on the negative side carries zero discharge
    a_dry_no_flux: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_depth_star_neg == '0) |-> (o_hu_star_neg == '0) && (o_hv_star_neg == '0))
        else $error("discharge on dry negative side");

    // Z dagger never exceeds the face bed
    a_dagger_le_fb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_bed_dagger_neg <= o_face_bed) && (o_bed_dagger_pos <= o_face_bed))
        else $error("Z dagger above face bed");

endmodule
